// File: hw/rtl/orlog_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// orlog_pkg
// shared types and constants for the overwriting ring log with key statistics
// ----------------------------------------------------------------------------
package orlog_pkg;

   localparam int unsigned LOG_DEPTH_DEFAULT = 64;

   localparam int unsigned KEY_W   = 16;
   localparam int unsigned SCORE_W = 7;
   localparam int unsigned COUNT_W = 7;
   localparam int unsigned TOTAL_W = 13;

   localparam logic [SCORE_W-1:0] PASS_MARK_RESET = SCORE_W'(40);
   localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX       = '1;

   typedef enum logic {
      FUNC_APPEND = 1'b0,
      FUNC_QUERY  = 1'b1
   } func_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] score;
   } record_type;

   typedef struct packed {
      logic clear;
      logic sample;
   } acc_ctrl_type;

endpackage
`default_nettype wire

// File: hw/rtl/orlog_acc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// orlog_acc
// saturating match, score and fail accumulators fed by the record scan
// ----------------------------------------------------------------------------
module orlog_acc (
   input  logic                                clock,
   input  logic                                reset,
   input  orlog_pkg::acc_ctrl_type             ctrl,
   input  logic [orlog_pkg::KEY_W-1:0]         key,
   input  logic [orlog_pkg::SCORE_W-1:0]       pass_mark,
   input  orlog_pkg::record_type               rec,
   output logic [orlog_pkg::COUNT_W-1:0]       match_count,
   output logic [orlog_pkg::TOTAL_W-1:0]       score_total,
   output logic [orlog_pkg::COUNT_W-1:0]       fail_count
);
   import orlog_pkg::*;

   logic [COUNT_W-1:0] match_ff, match_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [COUNT_W-1:0] fail_ff,  fail_in;
   logic [TOTAL_W:0]   total_sum;
   logic               hit;

   assign hit       = (rec.key == key);
   assign total_sum = {1'b0, total_ff} + (TOTAL_W+1)'(rec.score);

   always_comb begin
      match_in = match_ff;
      total_in = total_ff;
      fail_in  = fail_ff;
      if (ctrl.clear) begin
         match_in = '0;
         total_in = '0;
         fail_in  = '0;
      end else if (ctrl.sample && hit) begin
         if (match_ff != COUNT_MAX) begin
            match_in = match_ff + 1'b1;
         end
         // clamp the running sum at all ones
         total_in = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
         if ((rec.score < pass_mark) && (fail_ff != COUNT_MAX)) begin
            fail_in = fail_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= '0;
         total_ff <= '0;
         fail_ff  <= '0;
      end else begin
         match_ff <= match_in;
         total_ff <= total_in;
         fail_ff  <= fail_in;
      end
   end

   assign match_count = match_ff;
   assign score_total = total_ff;
   assign fail_count  = fail_ff;

`ifndef ASSERT_OFF
   a_fail_le_match : assert property (@(posedge clock) disable iff (reset)
      fail_ff <= match_ff)
      else $error("fail count above match count");

   a_clear_zero : assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> (match_ff == '0) && (total_ff == '0) && (fail_ff == '0))
      else $error("accumulators not cleared");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      (!ctrl.clear && !ctrl.sample) |=> $stable(match_ff) && $stable(total_ff)
                                          && $stable(fail_ff))
      else $error("accumulators moved without a sample");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/overwriting_ring_log_with_key_stats.sv
`default_nettype none
// ----------------------------------------------------------------------------
// overwriting_ring_log_with_key_stats
// circular (key, score) log with keyed match, sum and fail statistics
// ----------------------------------------------------------------------------
// usage
//   request channel (req_*): func 0 appends {learner_id, score} after the
//   newest record; once the log holds LOG_DEPTH records the oldest is
//   overwritten. func 1 asks for statistics on learner_id.
//   response channel (rsp_*): one response per query, none per append:
//   match count, score total and count of scores below the pass mark.
//   csr port: csr_write_en writes the 7-bit pass mark (reset value 40).
//   an append leaves the block in idle, so appends can arrive back to back.
//   a query walks the log oldest to newest, one record per cycle through the
//   single read port of the record memory; the response is loaded once the
//   last record read has been sampled and the response register is free;
//   the next request is taken the cycle after the load.
//   the response sits in an output register, so the next request is taken
//   while an earlier response waits for rsp_stall to drop.
//   reset empties the log (count and pointers only; the memory is not
//   cleared) and restores the pass mark. no clearing pass is needed.
//   while a query scans, req_stall stays high.
// ----------------------------------------------------------------------------
module overwriting_ring_log_with_key_stats #(
   parameter int unsigned LOG_DEPTH = orlog_pkg::LOG_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [orlog_pkg::KEY_W-1:0]         req_learner_id,
   input  logic [orlog_pkg::SCORE_W-1:0]       req_score,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [orlog_pkg::COUNT_W-1:0]       rsp_match_count,
   output logic [orlog_pkg::TOTAL_W-1:0]       rsp_score_total,
   output logic [orlog_pkg::COUNT_W-1:0]       rsp_fail_count,
   // configuration
   input  logic                                csr_write_en,
   input  logic [orlog_pkg::SCORE_W-1:0]       csr_write_data
);
   import orlog_pkg::*;

   localparam int unsigned PTR_W = $clog2(LOG_DEPTH);
   localparam int unsigned CNT_W = $clog2(LOG_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(LOG_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LOG_DEPTH);

   // record memory, one write and one registered read port
   record_type mem [LOG_DEPTH];

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]   remain_ff, remain_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [SCORE_W-1:0] pass_mark_ff;
   logic               rd_vld_ff;
   record_type         rd_data_ff;
   logic               rd_en;
   logic               mem_we;
   record_type         wr_data;
   logic               req_accept;
   logic               log_full;
   logic               out_free;
   logic               rsp_load;
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_match_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic [COUNT_W-1:0] rsp_fail_ff;
   acc_ctrl_type       acc_ctrl;
   logic [COUNT_W-1:0] acc_match;
   logic [TOTAL_W-1:0] acc_total;
   logic [COUNT_W-1:0] acc_fail;

   function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   assign req_accept = req_valid && !req_stall;
   assign log_full   = (count_ff == FULL_CNT);
   // response register can take a new value this cycle
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign wr_data    = '{key: req_learner_id, score: req_score};

   // sequencer: appends in idle, queries walk the log in scan
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      remain_in   = remain_ff;
      key_in      = key_ff;
      req_stall   = 1'b1;
      rd_en       = 1'b0;
      mem_we      = 1'b0;
      rsp_load    = 1'b0;
      acc_ctrl    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (func_type'(req_func) == FUNC_QUERY) begin
                  key_in         = req_learner_id;
                  scan_idx_in    = head_ff;
                  remain_in      = count_ff;
                  acc_ctrl.clear = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  // full log: drop the oldest record by moving the head
                  mem_we  = 1'b1;
                  tail_in = next_idx(tail_ff);
                  if (log_full) begin
                     head_in = next_idx(head_ff);
                  end else begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
         end
         ST_SCAN: begin
            // data read last cycle is in rd_data_ff now
            acc_ctrl.sample = rd_vld_ff;
            if (remain_ff != '0) begin
               rd_en       = 1'b1;
               scan_idx_in = next_idx(scan_idx_ff);
               remain_in   = remain_ff - 1'b1;
            end else if (!rd_vld_ff && out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= LAST_IDX;
         count_ff     <= '0;
         remain_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pass_mark_ff <= PASS_MARK_RESET;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
         rd_vld_ff <= rd_en;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_en) begin
            pass_mark_ff <= csr_write_data;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      key_ff      <= key_in;
      if (rsp_load) begin
         rsp_match_ff <= acc_match;
         rsp_total_ff <= acc_total;
         rsp_fail_ff  <= acc_fail;
      end
   end

   // record memory ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail_in] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[scan_idx_ff];
      end
   end

   orlog_acc u_acc (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (acc_ctrl),
      .key         (key_ff),
      .pass_mark   (pass_mark_ff),
      .rec         (rd_data_ff),
      .match_count (acc_match),
      .score_total (acc_total),
      .fail_count  (acc_fail)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_count = rsp_match_ff;
   assign rsp_score_total = rsp_total_ff;
   assign rsp_fail_count  = rsp_fail_ff;

`ifndef ASSERT_OFF
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("record count above log depth");

   a_full_stays_full : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (func_type'(req_func) == FUNC_APPEND) && log_full)
         |=> (count_ff == FULL_CNT) && (head_ff == next_idx($past(head_ff))))
      else $error("overwrite did not advance head at full log");

   a_read_in_scan : assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN) && !rsp_load)
      else $error("read data returned outside a scan or after response load");
`endif

endmodule
`default_nettype wire
